@@ src/cpm_pkg.sv @@
// Shared types and constants for the cell pack protection monitor.
package cpm_pkg;

    localparam int NUM_CELLS   = 6;
    localparam int CELL_W      = 16;
    localparam int THERM_W     = 12;
    localparam int CURRENT_W   = 16;
    localparam int PACK_V_W    = 19;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMPERATURE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CELL_VOLTAGE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_CELL_VOLTAGE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CURRENT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FAULT_DELTA      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BALANCE_DELTA    = 3'd5;

    typedef enum logic [1:0] {
        CELL_GOOD          = 2'd0,
        CELL_OVERHEAT      = 2'd1,
        CELL_OVER_VOLTAGE  = 2'd2,
        CELL_UNDER_VOLTAGE = 2'd3
    } cell_health_t;

    typedef enum logic [2:0] {
        PACK_GOOD         = 3'd0,
        PACK_OVERHEAT     = 3'd1,
        PACK_DELTA        = 3'd2,
        PACK_OVER_VOLTAGE = 3'd3,
        PACK_DEAD         = 3'd4,
        PACK_OVER_CURRENT = 3'd5
    } pack_health_t;

    typedef struct packed {
        logic [THERM_W-1:0]   max_temperature;
        logic [CELL_W-1:0]    max_cell_voltage;
        logic [CELL_W-1:0]    min_cell_voltage;
        logic [CURRENT_W-1:0] max_current;
        logic [CELL_W-1:0]    fault_delta;
        logic [CELL_W-1:0]    balance_delta;
    } cpm_cfg_t;

    typedef struct packed {
        logic [PACK_V_W-1:0]               pack_voltage;
        logic [THERM_W-1:0]                pack_temperature;
        pack_health_t                      pack_health;
        cell_health_t [NUM_CELLS-1:0]      health;
        logic [NUM_CELLS-1:0]              balance_mask;
        logic                              fault;
    } cpm_result_t;

endpackage

@@ src/cpm_eval.sv @@
// Combinational evaluation of one measurement round: sums, limits and health codes.
module cpm_eval (
    input  logic [cpm_pkg::NUM_CELLS-1:0][cpm_pkg::CELL_W-1:0] cells,
    input  logic [cpm_pkg::THERM_W-1:0]                        therm_a,
    input  logic [cpm_pkg::THERM_W-1:0]                        therm_b,
    input  logic [cpm_pkg::CURRENT_W-1:0]                      current,
    input  cpm_pkg::cpm_cfg_t                                  cfg,
    output cpm_pkg::cpm_result_t                               result
);

    logic [cpm_pkg::CELL_W-1:0]    min_01;
    logic [cpm_pkg::CELL_W-1:0]    min_23;
    logic [cpm_pkg::CELL_W-1:0]    min_45;
    logic [cpm_pkg::CELL_W-1:0]    min_0123;
    logic [cpm_pkg::CELL_W-1:0]    lowest;
    logic [cpm_pkg::THERM_W-1:0]   temp;
    logic                          overheat;
    logic                          over_current;
    logic [cpm_pkg::NUM_CELLS-1:0] over_v;
    logic [cpm_pkg::NUM_CELLS-1:0] under_v;
    logic [cpm_pkg::NUM_CELLS-1:0] delta_fault;
    logic [cpm_pkg::PACK_V_W-1:0]  sum_01;
    logic [cpm_pkg::PACK_V_W-1:0]  sum_23;
    logic [cpm_pkg::PACK_V_W-1:0]  sum_45;

    // Lowest cell through a small compare tree.
    always_comb
    begin
        min_01   = (cells[1] < cells[0]) ? cells[1] : cells[0];
        min_23   = (cells[3] < cells[2]) ? cells[3] : cells[2];
        min_45   = (cells[5] < cells[4]) ? cells[5] : cells[4];
        min_0123 = (min_23 < min_01) ? min_23 : min_01;
        lowest   = (min_45 < min_0123) ? min_45 : min_0123;
    end

    // Pack voltage as an adder tree; six 16-bit cells cannot overflow 19 bits.
    always_comb
    begin
        sum_01 = {3'b000, cells[0]} + {3'b000, cells[1]};
        sum_23 = {3'b000, cells[2]} + {3'b000, cells[3]};
        sum_45 = {3'b000, cells[4]} + {3'b000, cells[5]};
    end

    assign temp         = (therm_a > therm_b) ? therm_a : therm_b;
    assign overheat     = temp > cfg.max_temperature;
    assign over_current = current > cfg.max_current;

    // Per-cell limit checks, health codes and balancing.
    always_comb
    begin
        logic [cpm_pkg::CELL_W-1:0] delta;
        cpm_pkg::pack_health_t      pack;

        pack = cpm_pkg::PACK_GOOD;
        result.pack_voltage     = sum_01 + sum_23 + sum_45;
        result.pack_temperature = temp;
        result.balance_mask     = '0;
        for (int i = 0; i < cpm_pkg::NUM_CELLS; i++)
        begin
            delta          = cells[i] - lowest;
            over_v[i]      = cells[i] > cfg.max_cell_voltage;
            under_v[i]     = cells[i] < cfg.min_cell_voltage;
            delta_fault[i] = delta > cfg.fault_delta;

            // Later faults overwrite earlier ones, within a cell and across cells.
            result.health[i] = cpm_pkg::CELL_GOOD;
            if (overheat)
            begin
                result.health[i] = cpm_pkg::CELL_OVERHEAT;
                pack = cpm_pkg::PACK_OVERHEAT;
            end
            if (delta_fault[i])
            begin
                pack = cpm_pkg::PACK_DELTA;
            end
            if (over_v[i])
            begin
                result.health[i] = cpm_pkg::CELL_OVER_VOLTAGE;
                pack = cpm_pkg::PACK_OVER_VOLTAGE;
            end
            if (under_v[i])
            begin
                result.health[i] = cpm_pkg::CELL_UNDER_VOLTAGE;
                pack = cpm_pkg::PACK_DEAD;
            end
            result.balance_mask[i] = (delta > cfg.balance_delta) || over_v[i];
        end
        if (over_current)
        begin
            pack = cpm_pkg::PACK_OVER_CURRENT;
        end
        result.pack_health = pack;
        result.fault = overheat || over_current || (|over_v) || (|under_v) || (|delta_fault);
    end

endmodule

@@ src/cell_pack_protection_monitor.sv @@
// Top level of the cell pack protection monitor: registers, pipeline and trip latch.
//
//  channel   direction  handshake            payload
//  in        to block   in_valid / in_stall  cell_voltage_0..5, therm_a, therm_b, current
//  out       from block out_valid / out_stall pack results, cell health, balance, trip
//  cfg       to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A round passes from input transfer to result through one input register stage, then the
// evaluation logic into the result register. One round is taken every cycle unless in_stall.
// While the result register is held by out_stall the input stage still takes one more
// round; in_stall rises only when both stages are full and the output is stalled.
// Reset clears both valid flags, the trip latch and sets the limits to their defaults.
// Configuration writes are always taken (cfg_ready is held high).
module cell_pack_protection_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cpm_pkg::CELL_W-1:0]      cell_voltage_0,
    input  logic [cpm_pkg::CELL_W-1:0]      cell_voltage_1,
    input  logic [cpm_pkg::CELL_W-1:0]      cell_voltage_2,
    input  logic [cpm_pkg::CELL_W-1:0]      cell_voltage_3,
    input  logic [cpm_pkg::CELL_W-1:0]      cell_voltage_4,
    input  logic [cpm_pkg::CELL_W-1:0]      cell_voltage_5,
    input  logic [cpm_pkg::THERM_W-1:0]     therm_a,
    input  logic [cpm_pkg::THERM_W-1:0]     therm_b,
    input  logic [cpm_pkg::CURRENT_W-1:0]   current,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cpm_pkg::PACK_V_W-1:0]    pack_voltage,
    output logic [cpm_pkg::THERM_W-1:0]     pack_temperature,
    output logic [2:0]                      pack_health,
    output logic [1:0]                      health_0,
    output logic [1:0]                      health_1,
    output logic [1:0]                      health_2,
    output logic [1:0]                      health_3,
    output logic [1:0]                      health_4,
    output logic [1:0]                      health_5,
    output logic [cpm_pkg::NUM_CELLS-1:0]   balance_mask,
    output logic                            trip,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cpm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cpm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    cpm_pkg::cpm_cfg_t    cfg_reg;
    logic [cpm_pkg::NUM_CELLS-1:0][cpm_pkg::CELL_W-1:0] cells_reg;
    logic [cpm_pkg::THERM_W-1:0]   therm_a_reg;
    logic [cpm_pkg::THERM_W-1:0]   therm_b_reg;
    logic [cpm_pkg::CURRENT_W-1:0] current_reg;
    logic                          s1_valid_reg;
    logic                          out_valid_reg;
    logic                          trip_reg;
    logic                          trip_next;
    cpm_pkg::cpm_result_t          eval_result;
    cpm_pkg::cpm_result_t          result_reg;
    logic                          s2_load;
    logic                          s1_load;

    // Pipeline control: the result register loads when empty or being drained.
    assign s2_load   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s2_load;
    assign s1_load   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration registers; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_temperature  <= '1;
            cfg_reg.max_cell_voltage <= '1;
            cfg_reg.min_cell_voltage <= '0;
            cfg_reg.max_current      <= '1;
            cfg_reg.fault_delta      <= '1;
            cfg_reg.balance_delta    <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cpm_pkg::REG_MAX_TEMPERATURE:
                    cfg_reg.max_temperature <= cfg_data[cpm_pkg::THERM_W-1:0];
                cpm_pkg::REG_MAX_CELL_VOLTAGE: cfg_reg.max_cell_voltage <= cfg_data;
                cpm_pkg::REG_MIN_CELL_VOLTAGE: cfg_reg.min_cell_voltage <= cfg_data;
                cpm_pkg::REG_MAX_CURRENT:      cfg_reg.max_current      <= cfg_data;
                cpm_pkg::REG_FAULT_DELTA:      cfg_reg.fault_delta      <= cfg_data;
                cpm_pkg::REG_BALANCE_DELTA:    cfg_reg.balance_delta    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load || s2_load)
        begin
            s1_valid_reg <= s1_load;
        end
    end

    // Input stage payload.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            cells_reg   <= {cell_voltage_5, cell_voltage_4, cell_voltage_3,
                            cell_voltage_2, cell_voltage_1, cell_voltage_0};
            therm_a_reg <= therm_a;
            therm_b_reg <= therm_b;
            current_reg <= current;
        end
    end

    cpm_eval u_eval (
        .cells   (cells_reg),
        .therm_a (therm_a_reg),
        .therm_b (therm_b_reg),
        .current (current_reg),
        .cfg     (cfg_reg),
        .result  (eval_result)
    );

    // The trip latch takes the fault of each round as its result is registered.
    assign trip_next = trip_reg || (s2_load && eval_result.fault);

    // Result stage valid flag and trip latch.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            trip_reg      <= 1'b0;
        end
        else
        begin
            trip_reg <= trip_next;
            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            result_reg <= eval_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pack_voltage     = result_reg.pack_voltage;
    assign pack_temperature = result_reg.pack_temperature;
    assign pack_health      = result_reg.pack_health;
    assign health_0         = result_reg.health[0];
    assign health_1         = result_reg.health[1];
    assign health_2         = result_reg.health[2];
    assign health_3         = result_reg.health[3];
    assign health_4         = result_reg.health[4];
    assign health_5         = result_reg.health[5];
    assign balance_mask     = result_reg.balance_mask;
    assign trip             = trip_reg;

    // The trip latch never clears once set.
    a_trip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        trip_reg |=> trip_reg)
        else $error("trip latch cleared without reset");

    // The input side is only held off while both stages are full and the output is stalled.
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // Any reported pack fault must be reflected in the trip flag.
    a_fault_trips: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (result_reg.pack_health != cpm_pkg::PACK_GOOD)) |-> trip_reg)
        else $error("pack fault shown without trip");

    // A held result does not change while stalled.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(result_reg)))
        else $error("result changed while stalled");

    // The pack health code stays within its defined codes.
    a_pack_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.pack_health <= cpm_pkg::PACK_OVER_CURRENT))
        else $error("undefined pack health code");

endmodule

@@ verif/cell_pack_protection_monitor_test.sv @@
// Self-checking testbench for the cell pack protection monitor.
module cell_pack_protection_monitor_test;

    // Unmapped register indexes; writes to them must leave every limit alone.
    localparam logic [cpm_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [cpm_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int ROUNDS_PER_PHASE = 220;
    localparam int PHASE_COUNT      = 8;

    typedef struct packed {
        logic [cpm_pkg::NUM_CELLS-1:0][cpm_pkg::CELL_W-1:0] cell_v;
        logic [cpm_pkg::THERM_W-1:0]                        therm_a;
        logic [cpm_pkg::THERM_W-1:0]                        therm_b;
        logic [cpm_pkg::CURRENT_W-1:0]                      current;
    } meas_round_t;

    typedef struct packed {
        logic [cpm_pkg::PACK_V_W-1:0]                   pack_voltage;
        logic [cpm_pkg::THERM_W-1:0]                    pack_temperature;
        cpm_pkg::pack_health_t                          pack_health;
        cpm_pkg::cell_health_t [cpm_pkg::NUM_CELLS-1:0] health;
        logic [cpm_pkg::NUM_CELLS-1:0]                  balance_mask;
        logic                                           trip;
    } pack_report_t;

    typedef enum {
        LIM_TYPICAL,
        LIM_SPREAD,
        LIM_ZERO,
        LIM_ANY,
        LIM_TOP,
        LIM_DEFAULT
    } limit_profile_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [cpm_pkg::CELL_W-1:0]      cell_voltage_0 = '0;
    logic [cpm_pkg::CELL_W-1:0]      cell_voltage_1 = '0;
    logic [cpm_pkg::CELL_W-1:0]      cell_voltage_2 = '0;
    logic [cpm_pkg::CELL_W-1:0]      cell_voltage_3 = '0;
    logic [cpm_pkg::CELL_W-1:0]      cell_voltage_4 = '0;
    logic [cpm_pkg::CELL_W-1:0]      cell_voltage_5 = '0;
    logic [cpm_pkg::THERM_W-1:0]     therm_a = '0;
    logic [cpm_pkg::THERM_W-1:0]     therm_b = '0;
    logic [cpm_pkg::CURRENT_W-1:0]   current = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [cpm_pkg::PACK_V_W-1:0]    pack_voltage;
    logic [cpm_pkg::THERM_W-1:0]     pack_temperature;
    logic [2:0]                      pack_health;
    logic [1:0]                      health_0;
    logic [1:0]                      health_1;
    logic [1:0]                      health_2;
    logic [1:0]                      health_3;
    logic [1:0]                      health_4;
    logic [1:0]                      health_5;
    logic [cpm_pkg::NUM_CELLS-1:0]   balance_mask;
    logic                            trip;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [cpm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cpm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Testbench copy of the limits and of the sticky trip flag.
    cpm_pkg::cpm_cfg_t lim;
    logic              pack_tripped = 1'b0;

    meas_round_t  pending_rounds[$];
    pack_report_t expected_reports[$];
    meas_round_t  next_round;
    meas_round_t  offered_round;
    pack_report_t want;
    logic [cpm_pkg::NUM_CELLS-1:0][1:0] cell_health_seen;

    int  rounds_issued   = 0;
    int  rounds_accepted = 0;
    int  failures        = 0;
    int  send_idle_pct   = 34;
    int  recv_idle_pct   = 48;
    int  hold_cycles     = 0;
    bit  round_taken     = 1'b0;

    limit_profile_t phase_plan [PHASE_COUNT] = '{LIM_TYPICAL, LIM_SPREAD, LIM_ZERO, LIM_ANY,
                                                 LIM_TOP, LIM_SPREAD, LIM_DEFAULT, LIM_SPREAD};

    assign offered_round = {cell_voltage_5, cell_voltage_4, cell_voltage_3, cell_voltage_2,
                            cell_voltage_1, cell_voltage_0, therm_a, therm_b, current};
    assign cell_health_seen = {health_5, health_4, health_3, health_2, health_1, health_0};

    cell_pack_protection_monitor u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cell_voltage_0   (cell_voltage_0),
        .cell_voltage_1   (cell_voltage_1),
        .cell_voltage_2   (cell_voltage_2),
        .cell_voltage_3   (cell_voltage_3),
        .cell_voltage_4   (cell_voltage_4),
        .cell_voltage_5   (cell_voltage_5),
        .therm_a          (therm_a),
        .therm_b          (therm_b),
        .current          (current),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .pack_voltage     (pack_voltage),
        .pack_temperature (pack_temperature),
        .pack_health      (pack_health),
        .health_0         (health_0),
        .health_1         (health_1),
        .health_2         (health_2),
        .health_3         (health_3),
        .health_4         (health_4),
        .health_5         (health_5),
        .balance_mask     (balance_mask),
        .trip             (trip),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Works out the report for one measurement round and updates the trip flag.
    function automatic pack_report_t assess_round(input meas_round_t r);
        pack_report_t                 rep;
        logic [cpm_pkg::CELL_W-1:0]   lowest;
        logic [cpm_pkg::CELL_W-1:0]   delta;
        logic [cpm_pkg::THERM_W-1:0]  temp;
        logic [cpm_pkg::PACK_V_W-1:0] sum;
        bit                           fault;
        lowest = '1;
        sum    = '0;
        fault  = 1'b0;
        for (int i = 0; i < cpm_pkg::NUM_CELLS; i++)
        begin
            sum = sum + r.cell_v[i];
            if (r.cell_v[i] < lowest)
                lowest = r.cell_v[i];
        end
        temp = (r.therm_a > r.therm_b) ? r.therm_a : r.therm_b;
        rep.pack_voltage     = sum;
        rep.pack_temperature = temp;
        rep.pack_health      = cpm_pkg::PACK_GOOD;
        rep.balance_mask     = '0;
        // Later faults overwrite earlier ones, both per cell and across the pack.
        for (int i = 0; i < cpm_pkg::NUM_CELLS; i++)
        begin
            delta = r.cell_v[i] - lowest;
            rep.health[i] = cpm_pkg::CELL_GOOD;
            if (temp > lim.max_temperature)
            begin
                rep.health[i]   = cpm_pkg::CELL_OVERHEAT;
                rep.pack_health = cpm_pkg::PACK_OVERHEAT;
                fault = 1'b1;
            end
            if (delta > lim.fault_delta)
            begin
                rep.pack_health = cpm_pkg::PACK_DELTA;
                fault = 1'b1;
            end
            if (r.cell_v[i] > lim.max_cell_voltage)
            begin
                rep.health[i]   = cpm_pkg::CELL_OVER_VOLTAGE;
                rep.pack_health = cpm_pkg::PACK_OVER_VOLTAGE;
                fault = 1'b1;
            end
            if (r.cell_v[i] < lim.min_cell_voltage)
            begin
                rep.health[i]   = cpm_pkg::CELL_UNDER_VOLTAGE;
                rep.pack_health = cpm_pkg::PACK_DEAD;
                fault = 1'b1;
            end
            if (delta > lim.balance_delta || r.cell_v[i] > lim.max_cell_voltage)
                rep.balance_mask[i] = 1'b1;
        end
        if (r.current > lim.max_current)
        begin
            rep.pack_health = cpm_pkg::PACK_OVER_CURRENT;
            fault = 1'b1;
        end
        if (fault)
            pack_tripped = 1'b1;
        rep.trip = pack_tripped;
        return rep;
    endfunction

    function automatic int clamp_to(input int x, input int top);
        if (x < 0)
            return 0;
        if (x > top)
            return top;
        return x;
    endfunction

    // A round with every cell at the same voltage; callers adjust single cells.
    function automatic meas_round_t mk_round(input int volts, input int t_a, input int t_b,
                                             input int amps);
        meas_round_t r;
        for (int i = 0; i < cpm_pkg::NUM_CELLS; i++)
            r.cell_v[i] = 16'(volts);
        r.therm_a = 12'(t_a);
        r.therm_b = 12'(t_b);
        r.current = 16'(amps);
        return r;
    endfunction

    // Random round: mostly cells clustered near the current limits, some pure noise.
    function automatic meas_round_t rand_round();
        meas_round_t r;
        int          centre;
        int          spread;
        int          hot;
        int          pin;
        logic [cpm_pkg::THERM_W-1:0] swap_t;
        if ($urandom_range(99) < 25)
        begin
            for (int i = 0; i < cpm_pkg::NUM_CELLS; i++)
                r.cell_v[i] = 16'($urandom);
            r.therm_a = 12'($urandom);
            r.therm_b = 12'($urandom);
            r.current = 16'($urandom);
            return r;
        end
        centre = $urandom_range(int'(lim.min_cell_voltage), int'(lim.max_cell_voltage));
        case ($urandom_range(3))
            0: spread = 0;
            1: spread = int'(lim.balance_delta) + 2;
            2: spread = int'(lim.fault_delta) + 2;
            default: spread = $urandom_range(4000);
        endcase
        for (int i = 0; i < cpm_pkg::NUM_CELLS; i++)
            r.cell_v[i] = 16'(clamp_to(centre - spread / 2 + int'($urandom_range(spread)),
                                       65535));
        // Now and then pin one cell on or just past a voltage limit.
        if ($urandom_range(4) == 0)
        begin
            pin = $urandom_range(cpm_pkg::NUM_CELLS - 1);
            case ($urandom_range(3))
                0: r.cell_v[pin] = lim.max_cell_voltage;
                1: r.cell_v[pin] = 16'(clamp_to(int'(lim.max_cell_voltage) + 1, 65535));
                2: r.cell_v[pin] = lim.min_cell_voltage;
                default: r.cell_v[pin] = 16'(clamp_to(int'(lim.min_cell_voltage) - 1, 65535));
            endcase
        end
        if ($urandom_range(1) == 1)
        begin
            hot = clamp_to(int'(lim.max_temperature) + int'($urandom_range(6)) - 3, 4095);
            r.therm_a = 12'(hot);
            r.therm_b = 12'($urandom_range(hot));
            if ($urandom_range(1) == 1)
            begin
                swap_t    = r.therm_a;
                r.therm_a = r.therm_b;
                r.therm_b = swap_t;
            end
        end
        else
        begin
            r.therm_a = 12'($urandom);
            r.therm_b = 12'($urandom);
        end
        if ($urandom_range(1) == 1)
            r.current = 16'(clamp_to(int'(lim.max_current) + int'($urandom_range(6)) - 3, 65535));
        else
            r.current = 16'($urandom_range(int'(lim.max_current)));
        return r;
    endfunction

    function automatic cpm_pkg::cpm_cfg_t profile_limits(input limit_profile_t prof);
        cpm_pkg::cpm_cfg_t l;
        case (prof)
            LIM_TYPICAL:
            begin
                l.max_temperature  = 12'd3000;
                l.max_cell_voltage = 16'd42000;
                l.min_cell_voltage = 16'd30000;
                l.max_current      = 16'd20000;
                l.fault_delta      = 16'd800;
                l.balance_delta    = 16'd200;
            end
            LIM_SPREAD:
            begin
                l.max_temperature  = 12'($urandom_range(1000, 4000));
                l.min_cell_voltage = 16'($urandom_range(20000, 40000));
                l.max_cell_voltage = 16'(int'(l.min_cell_voltage) + int'($urandom_range(15000)));
                l.max_current      = 16'($urandom_range(1000, 60000));
                l.fault_delta      = 16'($urandom_range(3000));
                l.balance_delta    = 16'($urandom_range(int'(l.fault_delta)));
            end
            LIM_ZERO:
                l = '0;
            LIM_ANY:
            begin
                l.max_temperature  = 12'($urandom);
                l.max_cell_voltage = 16'($urandom);
                l.min_cell_voltage = 16'($urandom);
                l.max_current      = 16'($urandom);
                l.fault_delta      = 16'($urandom);
                l.balance_delta    = 16'($urandom);
            end
            LIM_TOP:
                l = '1;
            default:
            begin
                l = '1;
                l.min_cell_voltage = '0;
            end
        endcase
        return l;
    endfunction

    task automatic push_round(input meas_round_t r);
        pending_rounds.push_back(r);
        rounds_issued++;
    endtask

    // Returns once every round handed over has been transferred and answered.
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (rounds_accepted != rounds_issued || expected_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [cpm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [cpm_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            cpm_pkg::REG_MAX_TEMPERATURE:  lim.max_temperature  = data[cpm_pkg::THERM_W-1:0];
            cpm_pkg::REG_MAX_CELL_VOLTAGE: lim.max_cell_voltage = data;
            cpm_pkg::REG_MIN_CELL_VOLTAGE: lim.min_cell_voltage = data;
            cpm_pkg::REG_MAX_CURRENT:      lim.max_current      = data;
            cpm_pkg::REG_FAULT_DELTA:      lim.fault_delta      = data;
            cpm_pkg::REG_BALANCE_DELTA:    lim.balance_delta    = data;
            default: ;
        endcase
    endtask

    // Writes all six limits back to back; the temperature write carries junk upper bits.
    task automatic load_limits(input cpm_pkg::cpm_cfg_t l, input bit with_spare);
        write_reg(cpm_pkg::REG_MAX_TEMPERATURE, {4'($urandom), l.max_temperature});
        write_reg(cpm_pkg::REG_MAX_CELL_VOLTAGE, l.max_cell_voltage);
        write_reg(cpm_pkg::REG_MIN_CELL_VOLTAGE, l.min_cell_voltage);
        write_reg(cpm_pkg::REG_MAX_CURRENT, l.max_current);
        write_reg(cpm_pkg::REG_FAULT_DELTA, l.fault_delta);
        write_reg(cpm_pkg::REG_BALANCE_DELTA, l.balance_delta);
        if (with_spare)
        begin
            write_reg(REG_SPARE_LO, 16'($urandom));
            write_reg(REG_SPARE_HI, 16'($urandom));
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_v, got_v);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: offers the next pending round once the previous one has been transferred.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || round_taken))
        begin
            round_taken = 1'b0;
            if (pending_rounds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_round = pending_rounds.pop_front();
                in_valid       <= 1'b1;
                cell_voltage_0 <= next_round.cell_v[0];
                cell_voltage_1 <= next_round.cell_v[1];
                cell_voltage_2 <= next_round.cell_v[2];
                cell_voltage_3 <= next_round.cell_v[3];
                cell_voltage_4 <= next_round.cell_v[4];
                cell_voltage_5 <= next_round.cell_v[5];
                therm_a        <= next_round.therm_a;
                therm_b        <= next_round.therm_b;
                current        <= next_round.current;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: checks each result transfer, then predicts any input transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    failures++;
                    $display("%0t: result transfer with no round outstanding", $time);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("pack_voltage", 32'(want.pack_voltage), 32'(pack_voltage));
                    check_field("pack_temperature", 32'(want.pack_temperature),
                                32'(pack_temperature));
                    check_field("pack_health", 32'(want.pack_health), 32'(pack_health));
                    for (int i = 0; i < cpm_pkg::NUM_CELLS; i++)
                        check_field($sformatf("health_%0d", i), 32'(want.health[i]),
                                    32'(cell_health_seen[i]));
                    check_field("balance_mask", 32'(want.balance_mask), 32'(balance_mask));
                    check_field("trip", 32'(want.trip), 32'(trip));
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_reports.push_back(assess_round(offered_round));
                rounds_accepted++;
                round_taken = 1'b1;
            end
        end
    end

    // Stimulus: directed rounds, then random phases over a range of limits.
    initial
    begin
        meas_round_t r;
        lim = profile_limits(LIM_DEFAULT);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and alternating bit patterns under the reset limits.
        push_round(mk_round(0, 0, 0, 0));
        push_round(mk_round(65535, 4095, 4095, 65535));
        r = mk_round('h5555, 'h555, 'hAAA, 'h5555);
        r.cell_v[1] = 16'hAAAA;
        r.cell_v[3] = 16'hAAAA;
        r.cell_v[5] = 16'hAAAA;
        push_round(r);
        r = mk_round('hAAAA, 'hAAA, 'h555, 'hAAAA);
        r.cell_v[1] = 16'h5555;
        r.cell_v[3] = 16'h5555;
        r.cell_v[5] = 16'h5555;
        push_round(r);
        r = mk_round(40000, 100, 4095, 0);
        r.cell_v[2] = 16'd0;
        push_round(r);

        wait_quiet();
        load_limits(profile_limits(LIM_TYPICAL), 1'b1);
        @(posedge clk);

        // Each fault on its own, values on the limits, and overlapping faults.
        push_round(mk_round(36000, 1500, 1600, 5000));
        push_round(mk_round(36000, 3001, 200, 5000));
        push_round(mk_round(36000, 3000, 3000, 20000));
        push_round(mk_round(42000, 100, 100, 100));
        push_round(mk_round(30000, 100, 100, 100));
        r = mk_round(41900, 100, 100, 100);
        r.cell_v[2] = 16'd42001;
        push_round(r);
        r = mk_round(30100, 100, 100, 100);
        r.cell_v[4] = 16'd29999;
        push_round(r);
        r = mk_round(35000, 100, 100, 100);
        r.cell_v[3] = 16'd35801;
        push_round(r);
        r = mk_round(35000, 100, 100, 100);
        r.cell_v[3] = 16'd35800;
        r.cell_v[1] = 16'd35201;
        r.cell_v[5] = 16'd35200;
        push_round(r);
        push_round(mk_round(36000, 1000, 1000, 20001));
        r = mk_round(36000, 3500, 10, 100);
        r.cell_v[0] = 16'd42001;
        r.cell_v[5] = 16'd29999;
        push_round(r);
        r = mk_round(36000, 100, 100, 100);
        r.cell_v[0] = 16'd29999;
        r.cell_v[5] = 16'd42001;
        push_round(r);
        r = mk_round(35000, 100, 100, 100);
        r.cell_v[1] = 16'd29999;
        push_round(r);
        push_round(mk_round(42001, 100, 100, 65535));

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_quiet();
            load_limits(profile_limits(phase_plan[p]), 1'b0);
            @(posedge clk);
            if (p < 3)
            begin
                send_idle_pct = 34;
                recv_idle_pct = 48;
            end
            else if (p < 6)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 34;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < ROUNDS_PER_PHASE; n++)
                push_round(rand_round());
            // Hold the output long enough for the block to back up into its input.
            if (p == 0 || p == 6)
                hold_cycles = 60;
        end

        wait_quiet();
        repeat (6) @(posedge clk);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/cpm_pkg.sv
src/cpm_eval.sv
src/cell_pack_protection_monitor.sv
verif/cell_pack_protection_monitor_test.sv
